// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg - stable priority queue shared types
// Beat layouts of the command and result channels, command and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int KEY_BITS  = 32;
  localparam int PRIO_BITS = 16;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_CHANGE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [2:0]           command;
    logic [KEY_BITS-1:0]  element_key;
    logic [PRIO_BITS-1:0] priority_req;
    logic [PRIO_BITS-1:0] target_priority;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 key_present;
    logic [4:0]           entry_total;
    logic                 head_valid;
    logic [KEY_BITS-1:0]  head_key;
    logic [PRIO_BITS-1:0] head_priority;
  } spq_out_t;

endpackage

// ===== rtl/core/spq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/stable_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue - sorted priority queue with first-in first-out ties
// Commands arrive as beats on the in_ channel (valid/stall); each command
// yields exactly one result beat on the out_ channel with status, key
// presence, entry count and the head entry after the command.
// Entries live in one RAM in queue order, slot 0 being the head. Every
// command first scans the N held slots, then shifts slots down for a
// removal and up for an insertion, writes the new entry of an insertion,
// reads the head and loads the output register. A clear or a refused
// command skips the shifts and the write; a change adds its second scan
// and shift. The next command is accepted only once the result is loaded.
// in_stall is high while a command is being processed. A result waits in the
// output register under out_stall; the next command completes only once the
// register is free. Reset empties the queue at once; slots are not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  spq_pkg::spq_in_t in_beat,
  output logic             out_valid,
  input  logic             out_stall,
  output spq_pkg::spq_out_t out_beat
);
  import spq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = KEY_BITS + PRIO_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SC_RD  = 4'd1;
  localparam logic [3:0] S_SC_CMP = 4'd2;
  localparam logic [3:0] S_DN_RD  = 4'd3;
  localparam logic [3:0] S_DN_WR  = 4'd4;
  localparam logic [3:0] S_UP_RD  = 4'd5;
  localparam logic [3:0] S_UP_WR  = 4'd6;
  localparam logic [3:0] S_PUT    = 4'd7;
  localparam logic [3:0] S_HD_RD  = 4'd8;
  localparam logic [3:0] S_HD_CAP = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]           state_r, state_nxt;
  logic [2:0]           cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [PRIO_BITS-1:0] nprio_r, nprio_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 fk_r, fk_nxt;
  logic                 fkp_r, fkp_nxt;
  logic                 fi_r, fi_nxt;
  logic [CW-1:0]        kpos_r, kpos_nxt;
  logic [CW-1:0]        kppos_r, kppos_nxt;
  logic [CW-1:0]        ipos_r, ipos_nxt;
  logic                 pass2_r, pass2_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 hv_r, hv_nxt;
  logic [KEY_BITS-1:0]  hk_r, hk_nxt;
  logic [PRIO_BITS-1:0] hp_r, hp_nxt;
  spq_out_t             out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [DW-1:0]        ram_rdata;
  logic [KEY_BITS-1:0]  rd_key;
  logic [PRIO_BITS-1:0] rd_prio;
  logic [PRIO_BITS-1:0] scan_prio;

  spq_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key    = ram_rdata[DW-1:PRIO_BITS];
  assign rd_prio   = ram_rdata[PRIO_BITS-1:0];
  assign scan_prio = pass2_r ? nprio_r : prio_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    prio_nxt      = prio_r;
    nprio_nxt     = nprio_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    fk_nxt        = fk_r;
    fkp_nxt       = fkp_r;
    fi_nxt        = fi_r;
    kpos_nxt      = kpos_r;
    kppos_nxt     = kppos_r;
    ipos_nxt      = ipos_r;
    pass2_nxt     = pass2_r;
    status_nxt    = status_r;
    hv_nxt        = hv_r;
    hk_nxt        = hk_r;
    hp_nxt        = hp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_beat.command;
          key_nxt    = in_beat.element_key;
          prio_nxt   = in_beat.priority_req;
          nprio_nxt  = in_beat.target_priority;
          idx_nxt    = '0;
          fk_nxt     = 1'b0;
          fkp_nxt    = 1'b0;
          fi_nxt     = 1'b0;
          ipos_nxt   = count_r;
          pass2_nxt  = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_SC_RD;
        end
      end
      S_SC_RD: begin
        if (idx_r != count_r) begin
          state_nxt = S_SC_CMP;
        end else if (pass2_r) begin
          idx_nxt   = count_r;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_HD_RD;
          case (cmd_r)
            CMD_INSERT: begin
              if (count_r == CW'(QUEUE_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_UP_RD;
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DN_RD;
              end
            end
            CMD_REMOVE: begin
              if (!fk_r) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                idx_nxt   = kpos_r;
                state_nxt = S_DN_RD;
              end
            end
            CMD_CHANGE: begin
              if (!fkp_r) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                idx_nxt   = kppos_r;
                state_nxt = S_DN_RD;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SC_CMP: begin
        if (!pass2_r && !fk_r && rd_key == key_r) begin
          fk_nxt   = 1'b1;
          kpos_nxt = idx_r;
        end
        if (!pass2_r && !fkp_r && rd_key == key_r && rd_prio == prio_r) begin
          fkp_nxt   = 1'b1;
          kppos_nxt = idx_r;
        end
        if (!fi_r && rd_prio < scan_prio) begin
          fi_nxt   = 1'b1;
          ipos_nxt = idx_r;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SC_RD;
      end
      S_DN_RD: begin
        if (idx_r + CW'(1) < count_r) begin
          ram_raddr = AW'(idx_r + CW'(1));
          state_nxt = S_DN_WR;
        end else begin
          count_nxt = count_r - CW'(1);
          if (cmd_r == CMD_CHANGE) begin
            pass2_nxt = 1'b1;
            idx_nxt   = '0;
            fi_nxt    = 1'b0;
            ipos_nxt  = count_r - CW'(1);
            state_nxt = S_SC_RD;
          end else begin
            state_nxt = S_HD_RD;
          end
        end
      end
      S_DN_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_DN_RD;
      end
      S_UP_RD: begin
        if (idx_r > ipos_r) begin
          ram_raddr = AW'(idx_r - CW'(1));
          state_nxt = S_UP_WR;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_UP_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = S_UP_RD;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = ipos_r[AW-1:0];
        ram_wdata = {key_r, scan_prio};
        count_nxt = count_r + CW'(1);
        state_nxt = S_HD_RD;
      end
      S_HD_RD: begin
        ram_raddr = '0;
        state_nxt = S_HD_CAP;
      end
      S_HD_CAP: begin
        hv_nxt    = (count_r != '0);
        hk_nxt    = hv_nxt ? rd_key : '0;
        hp_nxt    = hv_nxt ? rd_prio : '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.status        = status_r;
          out_nxt.key_present   = fk_r;
          out_nxt.entry_total   = 5'(count_r);
          out_nxt.head_valid    = hv_r;
          out_nxt.head_key      = hk_r;
          out_nxt.head_priority = hp_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    prio_r   <= prio_nxt;
    nprio_r  <= nprio_nxt;
    idx_r    <= idx_nxt;
    fk_r     <= fk_nxt;
    fkp_r    <= fkp_nxt;
    fi_r     <= fi_nxt;
    kpos_r   <= kpos_nxt;
    kppos_r  <= kppos_nxt;
    ipos_r   <= ipos_nxt;
    pass2_r  <= pass2_nxt;
    status_r <= status_nxt;
    hv_r     <= hv_nxt;
    hk_r     <= hk_nxt;
    hp_r     <= hp_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule

// ===== rtl/core/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker - port-level checks for the stable priority queue
// Watches the command and result channels for protocol and consistency slips.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input spq_pkg::spq_out_t out_beat
);
  import spq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat dropped or changed under stall");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beat.head_valid == (out_beat.entry_total != 5'd0))
    else $error("head valid disagrees with entry count");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.status == ST_EMPTY |->
      out_beat.entry_total == 5'd0 && !out_beat.head_valid)
    else $error("empty status with entries held");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.status == ST_FULL |->
      out_beat.entry_total == 5'(QUEUE_DEPTH))
    else $error("full status with free slots");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted without going busy");

endmodule

bind stable_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);
